>>> rtl/core/u8dec_pkg.sv
// Shared types, constants and lead-byte decoding for the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [2:0]  t_count;
    typedef logic [30:0] t_code_point;

    localparam t_byte      C_CONT_SEL     = 8'hC0;
    localparam t_byte      C_CONT_TAG     = 8'h80;
    localparam logic [5:0] C_PAYLOAD_MASK = 6'h3F;

    // Sequence lengths a lead byte can announce
    localparam t_count C_LEN_NONE = 3'd0;
    localparam t_count C_LEN_1    = 3'd1;
    localparam t_count C_LEN_2    = 3'd2;
    localparam t_count C_LEN_3    = 3'd3;
    localparam t_count C_LEN_4    = 3'd4;
    localparam t_count C_LEN_5    = 3'd5;
    localparam t_count C_LEN_6    = 3'd6;

    // Length 0 marks a continuation or an illegal byte
    function automatic t_count lead_length(input t_byte b, input logic allow_long);
        t_count len;
        begin
            len = C_LEN_NONE;
            unique case (b[7:1]) inside
                [7'h00:7'h3F]: len = C_LEN_1;
                [7'h40:7'h5F]: len = C_LEN_NONE;
                [7'h60:7'h6F]: len = C_LEN_2;
                [7'h70:7'h77]: len = C_LEN_3;
                [7'h78:7'h7B]: len = C_LEN_4;
                [7'h7C:7'h7D]: len = allow_long ? C_LEN_5 : C_LEN_NONE;
                7'h7E:         len = allow_long ? C_LEN_6 : C_LEN_NONE;
                default:       len = C_LEN_NONE;
            endcase
            return len;
        end
    endfunction

    // Lead-byte payload: the byte masked by 0xFF >> (len + 1)
    function automatic logic [5:0] lead_payload(input t_byte b, input t_count len);
        logic [5:0] p;
        begin
            p = 6'd0;
            case (len)
                C_LEN_2: p = {1'b0, b[4:0]};
                C_LEN_3: p = {2'b0, b[3:0]};
                C_LEN_4: p = {3'b0, b[2:0]};
                C_LEN_5: p = {4'b0, b[1:0]};
                C_LEN_6: p = {5'b0, b[0]};
                default: p = 6'd0;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/utf8_to_code_point_decoder.sv
// UTF-8 byte stream to code point decoder, one byte per transaction.
// A byte accepted into the input register is decoded into the result register when the
//   decode stage advances, and o_out_valid rises once that register holds a code point.
// Throughput: 1 byte per cycle while no result stalls; the single decode stage between the
//   input and result registers sets this, and it advances whenever the result slot frees.
// Reset (i_rst_n low, synchronous): both registers empty, no sequence pending,
//   accumulator cleared, allow_long_forms set to 1.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_code_point_decoder
    import u8dec_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_stream,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [30:0] o_code_point,
    output logic        o_truncated
);

    logic        r_allow_long_forms;
    logic        r_in_valid;
    t_byte       r_in_byte;
    logic        r_in_eos;
    t_count      r_remaining, n_remaining;
    t_code_point r_acc, n_acc;
    logic        r_out_valid;
    t_code_point r_code_point, n_code_point;
    logic        r_truncated, n_truncated;
    logic        n_emit;
    logic        advance;
    logic        in_accept;
    logic        is_cont;
    t_count      len;
    t_code_point shifted;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_cont = (r_in_byte & C_CONT_SEL) == C_CONT_TAG;
    assign len     = lead_length(r_in_byte, r_allow_long_forms);
    assign shifted = {r_acc[24:0], r_in_byte[5:0] & C_PAYLOAD_MASK};

    always_comb begin
        n_remaining  = r_remaining;
        n_acc        = r_acc;
        n_emit       = 1'b0;
        n_code_point = r_acc;
        n_truncated  = 1'b0;
        if (r_in_eos) begin
            // flush a pending partial sequence
            n_emit       = r_remaining != C_LEN_NONE;
            n_truncated  = 1'b1;
            n_remaining  = C_LEN_NONE;
            n_acc        = '0;
        end else if (r_remaining != C_LEN_NONE && is_cont) begin
            n_remaining  = r_remaining - 3'd1;
            n_code_point = shifted;
            if (r_remaining == C_LEN_1) begin
                n_emit = 1'b1;
                n_acc  = '0;
            end else begin
                n_acc  = shifted;
            end
        end else begin
            // drop any pending sequence and treat the byte as a lead
            n_remaining = C_LEN_NONE;
            n_acc       = '0;
            if (len == C_LEN_1) begin
                n_emit       = 1'b1;
                n_code_point = {23'd0, r_in_byte};
            end else if (len != C_LEN_NONE) begin
                n_remaining = len - 3'd1;
                n_acc       = {25'd0, lead_payload(r_in_byte, len)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_long_forms <= 1'b1;
            r_in_valid         <= 1'b0;
            r_remaining        <= C_LEN_NONE;
            r_acc              <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_allow_long_forms <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_remaining <= n_remaining;
                r_acc       <= n_acc;
                r_out_valid <= n_emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
        if (advance && n_emit) begin
            r_code_point <= n_code_point;
            r_truncated  <= n_truncated;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_truncated  = r_truncated;

    // No sequence pending means an empty accumulator
    a_idle_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining == C_LEN_NONE |-> r_acc == '0)
        else $error("accumulator not clear while idle");

    // At most five continuation bytes are ever expected
    a_remaining_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= C_LEN_5)
        else $error("remaining count out of range");

    // Input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // A stalled result is neither lost nor altered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_code_point)
                                          && $stable(o_truncated)))
        else $error("stalled result changed");

    // A truncated result always follows an end marker
    a_trunc_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_emit && n_truncated) |-> r_in_eos)
        else $error("truncated result without end marker");

endmodule

`default_nettype wire

>>> sim/utf8_to_code_point_decoder_tb.sv
// Self-checking testbench for the UTF-8 to code point decoder.
`timescale 1ns / 1ps

module utf8_to_code_point_decoder_tb
    import u8dec_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_SLACK    = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_code_point code_point;
        logic        truncated;
    } t_decoded;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid  = 1'b0;
    t_byte       in_byte   = '0;
    logic        in_eos    = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    t_code_point out_code_point;
    logic        out_truncated;

    // Decoder state as predicted from accepted bytes
    t_count      seq_left      = C_LEN_NONE;
    t_code_point seq_value     = '0;
    logic        long_forms_on = 1'b1;

    t_decoded pending_code_points[$];
    int       mismatch_count = 0;
    int       bytes_sent     = 0;
    int       idle_cycles    = 0;
    int       src_idle_pct   = 11;
    int       sink_idle_pct  = 47;
    logic     hold_results   = 1'b0;

    utf8_to_code_point_decoder u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (in_byte),
        .i_end_of_stream (in_eos),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_code_point    (out_code_point),
        .o_truncated     (out_truncated)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stall, or a forced hold-off
    always @(negedge clk) begin
        if (hold_results) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("utf8_to_code_point_decoder verification failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        t_decoded want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_code_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result code point %h truncated %b",
                             $realtime, out_code_point, out_truncated);
            end else begin
                want = pending_code_points.pop_front();
                if (out_code_point !== want.code_point || out_truncated !== want.truncated) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected code point %h truncated %b, got %h %b",
                                 $realtime, want.code_point, want.truncated,
                                 out_code_point, out_truncated);
                end
            end
        end
    end

    function automatic t_count seq_length(input t_byte b);
        if (b < 8'h80) return C_LEN_1;
        if (b < 8'hC0) return C_LEN_NONE;
        if (b < 8'hE0) return C_LEN_2;
        if (b < 8'hF0) return C_LEN_3;
        if (b < 8'hF8) return C_LEN_4;
        if (!long_forms_on) return C_LEN_NONE;
        if (b < 8'hFC) return C_LEN_5;
        if (b < 8'hFE) return C_LEN_6;
        return C_LEN_NONE;
    endfunction

    // Advance the predicted state by one accepted byte, queue any code point
    function automatic void decode_byte(input t_byte b, input logic eos);
        t_count len;
        if (eos) begin
            if (seq_left != C_LEN_NONE)
                pending_code_points.push_back('{code_point: seq_value, truncated: 1'b1});
            seq_left  = C_LEN_NONE;
            seq_value = '0;
            return;
        end
        if (seq_left != C_LEN_NONE) begin
            if ((b & C_CONT_SEL) == C_CONT_TAG) begin
                seq_value = {seq_value[24:0], b[5:0]};
                seq_left  = seq_left - 3'd1;
                if (seq_left == C_LEN_NONE) begin
                    pending_code_points.push_back('{code_point: seq_value, truncated: 1'b0});
                    seq_value = '0;
                end
                return;
            end
            // abandon the sequence, then take this byte as a lead
            seq_left  = C_LEN_NONE;
            seq_value = '0;
        end
        len = seq_length(b);
        if (len == C_LEN_1) begin
            pending_code_points.push_back('{code_point: 31'(b), truncated: 1'b0});
        end else if (len != C_LEN_NONE) begin
            seq_value = 31'(b & (8'hFF >> (int'(len) + 1)));
            seq_left  = len - 3'd1;
        end
    endfunction

    task automatic send_byte(input t_byte b, input logic eos);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eos   <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        decode_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic send_bytes(input t_byte seq[]);
        foreach (seq[i]) send_byte(seq[i], 1'b0);
    endtask

    task automatic send_end(input t_byte b);
        send_byte(b, 1'b1);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold until all code points are in, then let the pipeline empty
    task automatic wait_drained();
        while (pending_code_points.size() != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_long_forms(input logic enable);
        release_input();
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= enable;
        @(negedge clk);
        cfg_we    <= 1'b0;
        long_forms_on = enable;
    endtask

    function automatic t_byte lead_byte(input int len);
        case (len)
            1:       return t_byte'($urandom_range(0, 127));
            2:       return 8'hC0 | t_byte'($urandom_range(0, 31));
            3:       return 8'hE0 | t_byte'($urandom_range(0, 15));
            4:       return 8'hF0 | t_byte'($urandom_range(0, 7));
            5:       return 8'hF8 | t_byte'($urandom_range(0, 3));
            default: return 8'hFC | t_byte'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic t_byte cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic send_char(input int len, input int n_cont);
        send_byte(lead_byte(len), 1'b0);
        repeat (n_cont) send_byte(cont_byte(), 1'b0);
    endtask

    task automatic test_directed();
        send_bytes('{8'h00, 8'h7F});
        send_bytes('{8'hC2, 8'hA9, 8'hDF, 8'hBF});
        send_bytes('{8'hEF, 8'hBF, 8'hBF});
        send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
        send_bytes('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
        // stray continuation and illegal bytes
        send_bytes('{8'h80, 8'hFE, 8'hFF});
        // interrupted by ASCII, then by a fresh lead
        send_bytes('{8'hE2, 8'h41, 8'hC3, 8'hE2, 8'h82});
        send_end(8'h00);
        send_byte(8'hF8, 1'b0);
        send_end(8'hFF);
        // end while idle, data byte ignored
        send_end(8'hC3);
    endtask

    task automatic test_long_forms_off();
        write_long_forms(1'b0);
        send_bytes('{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'hFC, 8'h80});
        send_bytes('{8'hE2, 8'hFD, 8'h41});
        // sequence left pending across a register write
        send_bytes('{8'hE2, 8'h82});
        write_long_forms(1'b1);
        send_bytes('{8'hAC, 8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80});
    endtask

    task automatic test_backpressure();
        fork
            begin
                @(posedge clk);
                hold_results = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            repeat (40) send_char($urandom_range(1, 4), 0);
        join
    endtask

    task automatic test_random_stream(input int n_bytes);
        int stop_at;
        int pick;
        int len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            len  = $urandom_range(1, 6);
            if (pick < 70) begin
                send_char(len, len - 1);
            end else if (pick < 80) begin
                len = $urandom_range(2, 6);
                send_char(len, $urandom_range(0, len - 2));
                send_end(t_byte'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                len = $urandom_range(2, 6);
                send_char(len, $urandom_range(0, len - 2));
            end else if (pick < 96) begin
                send_byte(t_byte'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_end(t_byte'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_long_forms_off();
        test_backpressure();
        test_random_stream(300);

        write_long_forms(1'b0);
        src_idle_pct  = 47;
        sink_idle_pct = 11;
        test_random_stream(300);

        write_long_forms(1'b1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_stream(300);

        release_input();
        wait_drained();
        if (pending_code_points.size() != 0) begin
            mismatch_count += pending_code_points.size();
            $display("%0d expected code points never arrived", pending_code_points.size());
        end
        if (mismatch_count == 0) begin
            $display("utf8_to_code_point_decoder verification clean");
        end else begin
            $display("utf8_to_code_point_decoder verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/u8dec_pkg.sv
rtl/core/utf8_to_code_point_decoder.sv
sim/utf8_to_code_point_decoder_tb.sv
